// ===== rtl/tnef_pkg.sv =====
package tnef_pkg;

  // Stream signature, little-endian on the wire
  localparam logic [31:0] SIG_MAGIC    = 32'h223e9f78;
  // Last byte index of the signature and of the key
  localparam logic [31:0] SIG_LAST_POS = 32'd3;
  localparam logic [31:0] KEY_LAST_POS = 32'd1;
  // Header: level byte, then attribute word (1..4), then size (5..8)
  localparam logic [31:0] HDR_WORD_END = 32'd4;
  localparam logic [31:0] HDR_LAST_POS = 32'd8;

  // Attribute that carries the embedded file contents
  localparam logic [7:0]  FILE_LEVEL   = 8'd2;
  localparam logic [15:0] FILE_ATTR_ID = 16'h800f;

  // One input transaction
  typedef struct packed {
    logic       start_of_file;
    logic [7:0] in_byte;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        file_data;
    logic        header_done;
    logic [7:0]  attr_level;
    logic [15:0] attr_type;
    logic [15:0] attr_id;
    logic [31:0] attr_size;
    logic        attr_done;
    logic        checksum_ok;
    logic        signature_bad;
  } result_t;

endpackage

// ===== rtl/tnef_attribute_deframer_core.sv =====
// TNEF attribute deframer.
// Slave side takes the raw stream one byte per transaction: s_tdata carries
// the byte, s_tuser flags a restart at the signature. Master side gives one
// result transaction per input byte, in order: the byte itself, its parse
// phase, payload and file-data flags, header/attribute completion, the
// checksum verdict and the current attribute header fields.
// m_tlast marks the second checksum byte, i.e. the end of an attribute.
// On acceptance the byte loads the input register; the parse logic output (a
// byte counter, a 16-bit adder and compares) then moves into the result
// register, whose valid flag drives m_tvalid.
// Throughput is one byte per cycle with m_tready held high.
// Reset clears both valid flags and the parse state (signature phase, byte
// count, header fields, checksum sum, bad-signature latch).
// When the receiver stalls, the result register holds its transaction, the
// input register takes one more byte, and s_tready then drops until
// m_tready returns; no byte is lost or repeated.
module tnef_attribute_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_tuser,   // [0] start_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] data_byte, [15:8] attr_level, [31:16] attr_type,
  // [47:32] attr_id, [79:48] attr_size
  output logic [79:0] m_tdata,
  // [2:0] phase, [3] data_valid, [4] file_data, [5] header_done,
  // [6] checksum_ok, [7] signature_bad
  output logic [7:0]  m_tuser,
  output logic        m_tlast    // attr_done
);
  import tnef_pkg::*;

  item_t   s_item;
  item_t   in_item;
  logic    in_valid;
  logic    take;
  logic    step;
  result_t parse_res;
  result_t out_res;

  assign s_item.in_byte       = s_tdata;
  assign s_item.start_of_file = s_tuser[0];

  // Pipeline advances when the result slot is empty or being drained
  assign take = !m_tvalid || m_tready;
  assign step = in_valid && take;

  tnef_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .item     (s_item),
    .take     (take),
    .valid    (in_valid),
    .q        (in_item)
  );

  tnef_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .res  (parse_res)
  );

  tnef_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_valid (in_valid),
    .d        (parse_res),
    .valid    (m_tvalid),
    .q        (out_res)
  );

  // Pack the result transaction
  assign m_tdata = {out_res.attr_size, out_res.attr_id, out_res.attr_type,
                    out_res.attr_level, out_res.data_byte};
  assign m_tuser = {out_res.signature_bad, out_res.checksum_ok,
                    out_res.header_done, out_res.file_data,
                    out_res.data_valid, out_res.phase};
  assign m_tlast = out_res.attr_done;

endmodule

// ===== rtl/tnef_in_reg.sv =====
module tnef_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  tnef_pkg::item_t item,
  input  logic            take,
  output logic            valid,
  output tnef_pkg::item_t q
);
  import tnef_pkg::*;

  // Room when empty or when the held byte moves on this cycle
  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      q <= item;
    end
  end

endmodule

// ===== rtl/tnef_parser.sv =====
module tnef_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tnef_pkg::item_t   item,
  output tnef_pkg::result_t res
);
  import tnef_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG = 3'd0,
    PH_KEY = 3'd1,
    PH_HDR = 3'd2,
    PH_PAY = 3'd3,
    PH_CHK = 3'd4
  } phase_t;

  // Parse state
  phase_t      phase;
  logic [31:0] pos;
  logic [7:0]  level;
  logic [31:0] word;
  logic [31:0] size;
  logic [15:0] sum;
  logic [7:0]  trailer_low;
  logic        bad;

  phase_t      phase_next;
  logic [31:0] pos_next;
  logic [7:0]  level_next;
  logic [31:0] word_next;
  logic [31:0] size_next;
  logic [15:0] sum_next;
  logic [7:0]  trailer_low_next;
  logic        bad_next;

  phase_t      phase_cur;
  phase_t      ph_out;
  logic [31:0] pos_cur;
  logic [7:0]  magic_byte;
  logic [1:0]  lane;
  logic        valid_o;
  logic        fdata_o;
  logic        hdone_o;
  logic        adone_o;
  logic        ckok_o;

  assign magic_byte = 8'(SIG_MAGIC >> {pos_cur[1:0], 3'b000});
  assign lane       = pos_cur[1:0] - 2'd1;

  // Next state and per-byte flags
  always_comb begin
    phase_cur        = phase;
    pos_cur          = pos;
    bad_next         = bad;
    if (item.start_of_file) begin
      phase_cur = PH_SIG;
      pos_cur   = '0;
      bad_next  = 1'b0;
    end
    if (!(phase_cur inside {PH_SIG, PH_KEY, PH_HDR, PH_PAY, PH_CHK})) begin
      phase_cur = PH_SIG;
      pos_cur   = '0;
    end

    phase_next       = phase_cur;
    pos_next         = pos_cur;
    level_next       = level;
    word_next        = word;
    size_next        = size;
    sum_next         = sum;
    trailer_low_next = trailer_low;
    ph_out           = phase_cur;
    valid_o          = 1'b0;
    fdata_o          = 1'b0;
    hdone_o          = 1'b0;
    adone_o          = 1'b0;
    ckok_o           = 1'b0;

    if (bad_next) begin
      // Latched mismatch: bytes pass through with only signature_bad set
      ph_out = PH_SIG;
    end else begin
      unique case (phase_cur)
        PH_SIG: begin
          if (item.in_byte != magic_byte) begin
            bad_next = 1'b1;
            pos_next = '0;
          end else if (pos_cur >= SIG_LAST_POS) begin
            phase_next = PH_KEY;
            pos_next   = '0;
          end else begin
            pos_next = pos_cur + 32'd1;
          end
        end
        PH_KEY: begin
          if (pos_cur >= KEY_LAST_POS) begin
            phase_next = PH_HDR;
            pos_next   = '0;
          end else begin
            pos_next = pos_cur + 32'd1;
          end
        end
        PH_HDR: begin
          if (pos_cur == '0) begin
            level_next = item.in_byte;
          end else if (pos_cur <= HDR_WORD_END) begin
            word_next[{lane, 3'b000} +: 8] = item.in_byte;
          end else begin
            size_next[{lane, 3'b000} +: 8] = item.in_byte;
          end
          if (pos_cur >= HDR_LAST_POS) begin
            hdone_o    = 1'b1;
            sum_next   = '0;
            pos_next   = '0;
            phase_next = (size_next != '0) ? PH_PAY : PH_CHK;
          end else begin
            pos_next = pos_cur + 32'd1;
          end
        end
        PH_PAY: begin
          valid_o  = 1'b1;
          fdata_o  = (level == FILE_LEVEL) && (word[15:0] == FILE_ATTR_ID);
          sum_next = sum + 16'(item.in_byte);
          if (({1'b0, pos_cur} + 33'd1) >= {1'b0, size}) begin
            phase_next = PH_CHK;
            pos_next   = '0;
          end else begin
            pos_next = pos_cur + 32'd1;
          end
        end
        PH_CHK: begin
          if (pos_cur == '0) begin
            trailer_low_next = item.in_byte;
            pos_next         = 32'd1;
          end else begin
            adone_o    = 1'b1;
            ckok_o     = ({item.in_byte, trailer_low} == sum);
            phase_next = PH_HDR;
            pos_next   = '0;
          end
        end
        default: begin
          phase_next = PH_SIG;
        end
      endcase
    end
  end

  // Result for this byte
  always_comb begin
    res.phase         = ph_out;
    res.data_byte     = item.in_byte;
    res.data_valid    = valid_o;
    res.file_data     = fdata_o;
    res.header_done   = hdone_o;
    res.attr_level    = level_next;
    res.attr_type     = word_next[31:16];
    res.attr_id       = word_next[15:0];
    res.attr_size     = size_next;
    res.attr_done     = adone_o;
    res.checksum_ok   = ckok_o;
    res.signature_bad = bad_next;
  end

  // State update, one byte per step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIG;
      pos         <= '0;
      level       <= '0;
      word        <= '0;
      size        <= '0;
      sum         <= '0;
      trailer_low <= '0;
      bad         <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      pos         <= pos_next;
      level       <= level_next;
      word        <= word_next;
      size        <= size_next;
      sum         <= sum_next;
      trailer_low <= trailer_low_next;
      bad         <= bad_next;
    end
  end

  // A latched mismatch only ever sits in the signature phase
  a_bad_in_sig: assert property (@(posedge clk) disable iff (rst)
    bad |-> phase == PH_SIG)
    else $error("bad signature latch outside signature phase");

  // Empty payload skips straight to the checksum
  a_empty_payload: assert property (@(posedge clk) disable iff (rst)
    (step && res.header_done && size_next == '0) |=> phase == PH_CHK)
    else $error("empty payload did not go to checksum");

  // End of an attribute returns to a fresh header
  a_attr_wrap: assert property (@(posedge clk) disable iff (rst)
    (step && res.attr_done) |=> (phase == PH_HDR && pos == '0))
    else $error("attribute end did not restart header");

  // Position bounds in the short phases
  a_chk_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHK |-> pos <= 32'd1)
    else $error("checksum position out of range");

  a_hdr_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HDR |-> pos <= HDR_LAST_POS)
    else $error("header position out of range");

endmodule

// ===== rtl/tnef_out_reg.sv =====
module tnef_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              in_valid,
  input  tnef_pkg::result_t d,
  output logic              valid,
  output tnef_pkg::result_t q
);
  import tnef_pkg::*;

  // Result register: loads whenever the downstream slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= in_valid;
    end
    if (take && in_valid) begin
      q <= d;
    end
  end

endmodule

// ===== verif/tnef_attribute_deframer_core_tb.sv =====
`timescale 1ns / 1ps

module tnef_attribute_deframer_core_tb;
  import tnef_pkg::*;

  // Parse phase codes as they appear in m_tuser[2:0]
  typedef enum bit [2:0] {
    PH_SIGNATURE = 3'd0,
    PH_KEY       = 3'd1,
    PH_HEADER    = 3'd2,
    PH_PAYLOAD   = 3'd3,
    PH_CHECKSUM  = 3'd4
  } parse_phase_t;

  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned MAX_WAIT     = 18;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned STREAM_BYTES = 1340;
  // Lane index that marks an intact signature
  localparam int unsigned NO_BAD_LANE  = 4;

  // Tracks the parser state, predicts each result and checks it in order
  class deframe_scoreboard;
    parse_phase_t cur_phase = PH_SIGNATURE;
    bit [31:0]    pos       = '0;
    bit [7:0]     level     = '0;
    bit [31:0]    word      = '0;
    bit [31:0]    len       = '0;
    bit [15:0]    sum       = '0;
    bit [7:0]     trail_lo  = '0;
    bit           sig_bad   = 1'b0;
    result_t      expected_q[$];
    int unsigned  failures  = 0;

    // Advance the parser by one byte and return what the block should report
    function result_t parse_byte(item_t it);
      result_t   r;
      bit [7:0]  b;
      bit [15:0] trailer;
      b = it.in_byte;
      r = '0;
      if (it.start_of_file) begin
        cur_phase = PH_SIGNATURE;
        pos = '0;
        sig_bad = 1'b0;
      end
      r.phase = sig_bad ? PH_SIGNATURE : cur_phase;
      if (!sig_bad) begin
        case (cur_phase)
          PH_SIGNATURE: begin
            if (b != SIG_MAGIC[8*pos[1:0] +: 8]) begin
              sig_bad = 1'b1;
              pos = '0;
            end else if (pos >= SIG_LAST_POS) begin
              cur_phase = PH_KEY;
              pos = '0;
            end else begin
              pos++;
            end
          end
          PH_KEY: begin
            if (pos >= KEY_LAST_POS) begin
              cur_phase = PH_HEADER;
              pos = '0;
            end else begin
              pos++;
            end
          end
          PH_HEADER: begin
            // level, then id/type word, then size, all little-endian
            if (pos == 0)
              level = b;
            else if (pos <= HDR_WORD_END)
              word[8*((pos - 1) % 4) +: 8] = b;
            else
              len[8*((pos - 5) % 4) +: 8] = b;
            if (pos >= HDR_LAST_POS) begin
              r.header_done = 1'b1;
              sum = '0;
              pos = '0;
              if (len != 0)
                cur_phase = PH_PAYLOAD;
              else
                cur_phase = PH_CHECKSUM;
            end else begin
              pos++;
            end
          end
          PH_PAYLOAD: begin
            r.data_valid = 1'b1;
            r.file_data = (level == FILE_LEVEL) && (word[15:0] == FILE_ATTR_ID);
            sum = sum + b;
            if ({1'b0, pos} + 33'd1 >= {1'b0, len}) begin
              cur_phase = PH_CHECKSUM;
              pos = '0;
            end else begin
              pos++;
            end
          end
          default: begin
            if (pos == 0) begin
              trail_lo = b;
              pos = 32'd1;
            end else begin
              trailer = {b, trail_lo};
              r.attr_done = 1'b1;
              r.checksum_ok = (trailer == sum);
              cur_phase = PH_HEADER;
              pos = '0;
            end
          end
        endcase
      end
      r.data_byte = b;
      r.attr_level = level;
      r.attr_type = word[31:16];
      r.attr_id = word[15:0];
      r.attr_size = len;
      r.signature_bad = sig_bad;
      return r;
    endfunction

    function void accept_byte(item_t it);
      expected_q.push_back(parse_byte(it));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
        failures++;
      end
    endfunction

    function void check_result(result_t seen);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected, expected none, actual %h",
                 $time, seen);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("phase", want.phase, seen.phase);
      compare_field("data_byte", want.data_byte, seen.data_byte);
      compare_field("data_valid", want.data_valid, seen.data_valid);
      compare_field("file_data", want.file_data, seen.file_data);
      compare_field("header_done", want.header_done, seen.header_done);
      compare_field("attr_level", want.attr_level, seen.attr_level);
      compare_field("attr_type", want.attr_type, seen.attr_type);
      compare_field("attr_id", want.attr_id, seen.attr_id);
      compare_field("attr_size", want.attr_size, seen.attr_size);
      compare_field("attr_done", want.attr_done, seen.attr_done);
      compare_field("checksum_ok", want.checksum_ok, seen.checksum_ok);
      compare_field("signature_bad", want.signature_bad, seen.signature_bad);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [7:0]  m_tuser;
  logic        m_tlast;

  deframe_scoreboard sb = new;
  item_t             stream_q[$];
  int unsigned       idle_cycles = 0;

  tnef_attribute_deframer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stream building helpers
  function automatic void queue_byte(bit [7:0] b, bit sof);
    item_t it;
    it.in_byte = b;
    it.start_of_file = sof;
    stream_q.push_back(it);
  endfunction

  // Signature (optionally broken at one lane, which ends it there), then the key if intact
  function automatic void queue_file_head(int unsigned bad_lane);
    bit [7:0] b;
    for (int lane = 0; lane < 4; lane++) begin
      b = SIG_MAGIC[8*lane +: 8];
      if (lane == bad_lane) begin
        b = b ^ 8'($urandom_range(1, 255));
        queue_byte(b, lane == 0);
        return;
      end
      queue_byte(b, lane == 0);
    end
    queue_byte(8'($urandom_range(0, 255)), 1'b0);
    queue_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // Header, payload and trailer; stops early when fewer bytes are sent than len
  function automatic void queue_attribute(bit [7:0] lvl, bit [15:0] atype, bit [15:0] aid,
                                          bit [31:0] len, int unsigned sent, bit corrupt);
    bit [7:0]  b;
    bit [15:0] chk;
    chk = '0;
    queue_byte(lvl, 1'b0);
    queue_byte(aid[7:0], 1'b0);
    queue_byte(aid[15:8], 1'b0);
    queue_byte(atype[7:0], 1'b0);
    queue_byte(atype[15:8], 1'b0);
    for (int i = 0; i < 4; i++)
      queue_byte(len[8*i +: 8], 1'b0);
    for (int unsigned i = 0; i < sent; i++) begin
      b = 8'($urandom_range(0, 255));
      chk = chk + b;
      queue_byte(b, 1'b0);
    end
    if (sent == len) begin
      if (corrupt)
        chk = chk ^ 16'($urandom_range(1, 65535));
      queue_byte(chk[7:0], 1'b0);
      queue_byte(chk[15:8], 1'b0);
    end
  endfunction

  // Idle count per transaction; each side flips between calm and busy runs
  function automatic int unsigned pick_idle(inout bit calm);
    if ($urandom_range(0, 39) == 0)
      calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic send_item(input item_t it, input int unsigned gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= it.in_byte;
    s_tuser <= it.start_of_file;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    bit          send_calm;
    int unsigned gap;
    bit [7:0]    lvl;
    bit [15:0]   aid;
    bit [31:0]   len;
    send_calm = 1'b0;

    // Directed: broken signature with ignored bytes, file-data attribute with
    // extreme header values, empty payload with a bad checksum
    queue_file_head(3);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_file_head(NO_BAD_LANE);
    queue_attribute(FILE_LEVEL, 16'hffff, FILE_ATTR_ID, 32'd1, 1, 1'b0);
    queue_attribute(8'hff, 16'h0000, 16'hffff, 32'd0, 0, 1'b1);

    // Random files: mostly well formed, some broken or cut short
    while (stream_q.size() < STREAM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_file_head($urandom_range(0, 3));
        repeat ($urandom_range(0, 5)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        queue_file_head(NO_BAD_LANE);
        repeat ($urandom_range(1, 6)) begin
          lvl = ($urandom_range(0, 2) == 0) ? FILE_LEVEL : 8'($urandom_range(0, 255));
          aid = ($urandom_range(0, 2) == 0) ? FILE_ATTR_ID : 16'($urandom_range(0, 65535));
          len = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
          queue_attribute(lvl, 16'($urandom_range(0, 65535)), aid, len, len,
                          $urandom_range(0, 7) == 0);
        end
        case ($urandom_range(0, 9))
          0: begin
            // huge size, payload cut short by the next restart
            len = $urandom | 32'h100;
            queue_attribute(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), len, $urandom_range(0, 6), 1'b0);
          end
          1: repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
          default: ;
        endcase
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    foreach (stream_q[i]) begin
      gap = pick_idle(send_calm);
      send_item(stream_q[i], gap);
    end
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Receiver with random stalls
  initial begin
    bit          recv_calm;
    int unsigned gap;
    recv_calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = pick_idle(recv_calm);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Monitor both sides
  always @(posedge clk) begin
    item_t   taken;
    result_t seen;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        taken.in_byte = s_tdata;
        taken.start_of_file = s_tuser[0];
        sb.accept_byte(taken);
      end
      if (m_tvalid && m_tready) begin
        seen.data_byte = m_tdata[7:0];
        seen.attr_level = m_tdata[15:8];
        seen.attr_type = m_tdata[31:16];
        seen.attr_id = m_tdata[47:32];
        seen.attr_size = m_tdata[79:48];
        seen.phase = m_tuser[2:0];
        seen.data_valid = m_tuser[3];
        seen.file_data = m_tuser[4];
        seen.header_done = m_tuser[5];
        seen.checksum_ok = m_tuser[6];
        seen.signature_bad = m_tuser[7];
        seen.attr_done = m_tlast;
        sb.check_result(seen);
      end
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
